[src/stq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Shared widths, request and result codes, and the entry record type.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int QUEUE_DEPTH  = 32;
    localparam int TASK_ID_BITS = 8;
    localparam int TIME_BITS    = 48;
    localparam int DELAY_BITS   = 32;
    localparam int IDX_BITS     = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] KIND_SCHED  = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_DISABLED = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef struct packed {
        logic [TIME_BITS-1:0]    expiry;
        logic [DELAY_BITS-1:0]   period;
        logic [TASK_ID_BITS-1:0] task_id;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    // Saturating time add, one wide add and compare.
    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [DELAY_BITS-1:0] d);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {{(TIME_BITS + 1 - DELAY_BITS){1'b0}}, d};
        if (s[TIME_BITS] || s[TIME_BITS-1:0] == TIME_MAX) begin
            return TIME_MAX;
        end
        return s[TIME_BITS-1:0];
    endfunction

endpackage

[src/sorted_timer_event_queue_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer event queue
// Timer entries sorted by expiry in one RAM, walked by a sequencer.
// ----------------------------------------------------------------------------
// Operation: a schedule searches for its place and then shifts later entries up; a
// cancel searches by task_id and shifts later entries down; a refused request is
// answered without a search. A tick fires each due entry in turn, then compacts the
// queue and re-inserts each periodic entry by a sorted insert; a stalled receiver holds it.
// Throughput: one request at a time; RAM entries are read or moved one by one.
// Reset: synchronous active-low aresetn clears time, count, enable and sequencer.
module sorted_timer_event_queue_top
    import stq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: task_id[7:0], delay[39:8], repeat_req[40], zero fill to 48
    input  logic [47:0] s_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: status[1:0], task_id_out[9:2], fire_time[57:10], zero fill to 64
    output logic [63:0] m_tdata,
    // tuser: result_kind[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRCH   = 4'd1;  // read slot at idx
    localparam logic [3:0] S_SRCHW  = 4'd2;  // compare read data
    localparam logic [3:0] S_SHUP   = 4'd3;  // read idx-1 for shift up
    localparam logic [3:0] S_SHUPW  = 4'd4;  // write it at idx
    localparam logic [3:0] S_SHDN   = 4'd5;  // read idx+off for shift down
    localparam logic [3:0] S_SHDNW  = 4'd6;  // write it at idx
    localparam logic [3:0] S_FRD    = 4'd7;  // read head candidate
    localparam logic [3:0] S_FCHK   = 4'd8;  // due check
    localparam logic [3:0] S_OUT    = 4'd9;  // wait for result slot
    localparam logic [3:0] S_RLD    = 4'd10; // reload next periodic entry

    logic [3:0]              state_reg, state_next;
    logic                    enable_reg;
    logic [TIME_BITS-1:0]    time_reg, time_next;
    logic [CNT_BITS-1:0]     count_reg, count_next;
    logic [CNT_BITS-1:0]     idx_reg, idx_next;
    logic [CNT_BITS-1:0]     nfire_reg, nfire_next;
    logic [CNT_BITS-1:0]     rld_reg, rld_next;
    logic [1:0]              kind_reg, kind_next;
    entry_t                  new_reg, new_next;
    logic                    fire_mode_reg, fire_mode_next;

    // Fired periodic entries wait here in firing order; at most one per slot.
    entry_t                  rq_mem [QUEUE_DEPTH];
    logic [CNT_BITS-1:0]     rq_cnt_reg, rq_cnt_next;
    logic                    rq_we;
    entry_t                  rq_wdata;

    logic                    m_valid_reg, m_valid_next;
    logic [63:0]             m_data_reg, m_data_next;
    logic [1:0]              m_user_reg, m_user_next;
    logic                    m_last_reg, m_last_next;

    // Previous fired entry, shown once the next due check has been made.
    logic [TASK_ID_BITS-1:0] m_hold_task;
    logic [TIME_BITS-1:0]    m_hold_time;

    logic                    ram_we;
    logic [IDX_BITS-1:0]     ram_waddr, ram_raddr;
    entry_t                  ram_wdata, ram_rdata;
    entry_t                  rq_head;

    stq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENTRY_BITS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The reload queue is read ahead, addressed by the next reload index, so rq_head matches rld_reg.
    always_ff @(posedge aclk) begin
        if (rq_we) begin
            rq_mem[rq_cnt_reg[IDX_BITS-1:0]] <= rq_wdata;
        end
        rq_head <= rq_mem[rld_next[IDX_BITS-1:0]];
    end

    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    function automatic logic [63:0] pack_out(input logic [1:0] st,
                                             input logic [TASK_ID_BITS-1:0] tk,
                                             input logic [TIME_BITS-1:0] ft);
        return {6'd0, ft, tk, st};
    endfunction

    always_comb begin
        state_next     = state_reg;
        time_next      = time_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        nfire_next     = nfire_reg;
        rld_next       = rld_reg;
        kind_next      = kind_reg;
        new_next       = new_reg;
        fire_mode_next = fire_mode_reg;
        rq_cnt_next    = rq_cnt_reg;
        rq_we          = 1'b0;
        rq_wdata       = ram_rdata;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        m_last_next    = m_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg[IDX_BITS-1:0];
        ram_wdata      = new_reg;
        ram_raddr      = idx_reg[IDX_BITS-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    kind_next        = s_tuser;
                    new_next.task_id = s_tdata[7:0];
                    new_next.expiry  = sat_add(time_reg, s_tdata[39:8]);
                    new_next.period  = s_tdata[40] ? s_tdata[39:8] : '0;
                    idx_next         = '0;
                    fire_mode_next   = 1'b0;
                    m_user_next      = s_tuser;
                    m_last_next      = 1'b1;
                    case (s_tuser)
                        KIND_SCHED: begin
                            if (!enable_reg) begin
                                m_valid_next = 1'b1;
                                m_data_next  = pack_out(ST_DISABLED, s_tdata[7:0], '0);
                            end else if (count_reg == CNT_BITS'(QUEUE_DEPTH)) begin
                                m_valid_next = 1'b1;
                                m_data_next  = pack_out(ST_FULL, s_tdata[7:0], '0);
                            end else begin
                                state_next = S_SRCH;
                            end
                        end
                        KIND_CANCEL: begin
                            if (!enable_reg) begin
                                m_valid_next = 1'b1;
                                m_data_next  = pack_out(ST_DISABLED, s_tdata[7:0], '0);
                            end else begin
                                state_next = S_SRCH;
                            end
                        end
                        KIND_TICK: begin
                            time_next = sat_add(time_reg, DELAY_BITS'(1));
                            if (enable_reg) begin
                                nfire_next  = '0;
                                rq_cnt_next = '0;
                                state_next  = S_FRD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SRCH: begin
                if (idx_reg == count_reg) begin
                    if (kind_reg == KIND_CANCEL) begin
                        m_valid_next = 1'b1;
                        m_data_next  = pack_out(ST_NOTFOUND, new_reg.task_id, '0);
                        state_next   = S_IDLE;
                    end else begin
                        // Every entry is earlier: append at the tail.
                        nfire_next = count_reg;
                        idx_next   = count_reg;
                        state_next = S_SHUP;
                    end
                end else begin
                    state_next = S_SRCHW;
                end
            end
            S_SRCHW: begin
                if (kind_reg == KIND_CANCEL) begin
                    if (ram_rdata.task_id == new_reg.task_id) begin
                        nfire_next = CNT_BITS'(1);
                        state_next = S_SHDN;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SRCH;
                    end
                end else if (new_reg.expiry > ram_rdata.expiry) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SRCH;
                end else begin
                    // Insert position found: open a gap from the tail down.
                    nfire_next = idx_reg;
                    idx_next   = count_reg;
                    state_next = S_SHUP;
                end
            end
            S_SHUP: begin
                // nfire_reg holds the insert position here.
                if (idx_reg == nfire_reg || (kind_reg == KIND_SCHED && idx_reg == count_reg
                        && nfire_reg == count_reg)) begin
                    ram_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (fire_mode_reg) begin
                        rld_next   = rld_reg + 1'b1;
                        state_next = S_RLD;
                    end else begin
                        m_valid_next = 1'b1;
                        m_data_next  = pack_out(ST_OK, new_reg.task_id, '0);
                        state_next   = S_IDLE;
                    end
                end else begin
                    ram_raddr  = IDX_BITS'(idx_reg - 1'b1);
                    state_next = S_SHUPW;
                end
            end
            S_SHUPW: begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                idx_next   = idx_reg - 1'b1;
                state_next = S_SHUP;
            end
            S_SHDN: begin
                // Move entries down by nfire_reg slots, starting at idx_reg.
                if ({1'b0, idx_reg} + {1'b0, nfire_reg} >= {1'b0, count_reg}) begin
                    count_next = count_reg - nfire_reg;
                    if (kind_reg == KIND_CANCEL) begin
                        m_valid_next = 1'b1;
                        m_data_next  = pack_out(ST_OK, new_reg.task_id, '0);
                        state_next   = S_IDLE;
                    end else begin
                        rld_next       = '0;
                        fire_mode_next = 1'b1;
                        state_next     = S_RLD;
                    end
                end else begin
                    ram_raddr  = IDX_BITS'(idx_reg + nfire_reg);
                    state_next = S_SHDNW;
                end
            end
            S_SHDNW: begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                idx_next   = idx_reg + 1'b1;
                state_next = S_SHDN;
            end
            S_FRD: begin
                ram_raddr = IDX_BITS'(nfire_reg);
                if (nfire_reg == count_reg) begin
                    state_next = S_FCHK;
                end else begin
                    state_next = S_FCHK;
                end
            end
            S_FCHK: begin
                // Keep reading the same slot so the check can be repeated.
                ram_raddr = IDX_BITS'(nfire_reg);
                if (nfire_reg != count_reg && ram_rdata.expiry <= time_reg) begin
                    new_next   = ram_rdata;
                    state_next = S_OUT;
                    if (ram_rdata.period != '0) begin
                        rq_we       = 1'b1;
                        rq_cnt_next = rq_cnt_reg + 1'b1;
                    end
                end else if (nfire_reg == '0) begin
                    state_next = S_IDLE;
                end else if (m_valid_reg && !m_tready) begin
                    // The previous fired result is still waiting for the receiver.
                    state_next = S_FCHK;
                end else begin
                    // Last fired result goes out flagged; then compact.
                    m_valid_next = 1'b1;
                    m_data_next  = pack_out(ST_OK, new_reg.task_id, new_reg.expiry);
                    m_user_next  = KIND_TICK;
                    m_last_next  = 1'b1;
                    idx_next     = '0;
                    state_next   = S_SHDN;
                end
            end
            S_OUT: begin
                // Hold the previous fired entry until the next one shows
                // whether it is last.
                if (!m_valid_reg || m_tready) begin
                    if (nfire_reg != '0) begin
                        m_valid_next = 1'b1;
                        m_data_next  = pack_out(ST_OK, m_hold_task, m_hold_time);
                        m_user_next  = KIND_TICK;
                        m_last_next  = 1'b0;
                    end
                    nfire_next = nfire_reg + 1'b1;
                    state_next = S_FRD;
                end
            end
            S_RLD: begin
                if (m_valid_reg && !m_tready) begin
                    state_next = S_RLD;
                end else if (rld_reg == rq_cnt_reg) begin
                    state_next = S_IDLE;
                end else begin
                    new_next.task_id = rq_head.task_id;
                    new_next.period  = rq_head.period;
                    new_next.expiry  = sat_add(time_reg, rq_head.period);
                    kind_next        = KIND_SCHED;
                    idx_next         = '0;
                    state_next       = S_SRCH;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && (!m_valid_reg || m_tready)) begin
            m_hold_task <= new_reg.task_id;
            m_hold_time <= new_reg.expiry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            enable_reg    <= 1'b0;
            time_reg      <= '0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
            rq_cnt_reg    <= '0;
            fire_mode_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
            rq_cnt_reg    <= rq_cnt_next;
            fire_mode_reg <= fire_mode_next;
            if (cfg_we) begin
                enable_reg <= cfg_wdata;
            end
        end
        idx_reg    <= idx_next;
        nfire_reg  <= nfire_next;
        rld_reg    <= rld_next;
        kind_reg   <= kind_next;
        new_reg    <= new_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

endmodule

[src/stq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer queue entry RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module stq_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
